FILE: design/ipv4hc_pkg.sv
`default_nettype none

package ipv4hc_pkg;

  // Slot search and configuration register file.
  localparam int NUM_SLOTS   = 4;
  localparam int REG_COUNT   = 4;
  localparam int SLOT_W      = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int SLOT_REG_W  = 9;
  localparam int SLOT_EN_BIT = 8;

  // Header constants.
  localparam logic [15:0] MIN_HDR_BYTES   = 16'd20;
  localparam logic [3:0]  IP_VER_EXPECTED = 4'd4;
  localparam logic [3:0]  IHL_MIN         = 4'd5;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [SLOT_REG_W-1:0] SLOT0_RESET = {1'b1, PROTO_ICMP};

  // Byte offsets of the captured header fields.
  localparam logic [15:0] OFS_VER_IHL  = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI  = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO  = 16'd3;
  localparam logic [15:0] OFS_PROTO    = 16'd9;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

  // Result width: status, slot, protocol, header bytes, payload bytes.
  localparam int RESULT_W   = 3 + SLOT_W + 8 + 6 + 16;
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_ACCEPT     = 3'd0,
    ST_SHORT      = 3'd1,
    ST_VERSION    = 3'd2,
    ST_IHL        = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_NO_HANDLER = 3'd6
  } status_t;

  // Packet state as it stands once the current byte has been folded in.
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  ver_ihl;
    logic [15:0] tlen;
    logic [7:0]  proto;
    logic [15:0] sum;
  } pkt_view_t;

  // Ones-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

FILE: design/ipv4hc_hdr_track.sv
`default_nettype none

module ipv4hc_hdr_track (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  is_last,
  output ipv4hc_pkg::pkt_view_t      view
);
  import ipv4hc_pkg::*;

  logic [15:0] count_r, count_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [5:0]  hl_here;

  // Fold the byte at the current offset into the captured fields and the sum.
  always_comb begin
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
    ver_nxt   = (count_r == OFS_VER_IHL) ? data_byte : ver_r;
    tlen_nxt  = tlen_r;
    if (count_r == OFS_TLEN_HI) begin
      tlen_nxt[15:8] = data_byte;
    end
    if (count_r == OFS_TLEN_LO) begin
      tlen_nxt[7:0] = data_byte;
    end
    proto_nxt = (count_r == OFS_PROTO) ? data_byte : proto_r;
    hl_here   = {ver_nxt[3:0], 2'b00};
    hold_nxt  = hold_r;
    sum_nxt   = sum_r;
    if (count_r < {10'd0, hl_here}) begin
      if (!count_r[0]) begin
        hold_nxt = data_byte;
      end else begin
        sum_nxt = ones_add(sum_r, {hold_r, data_byte});
      end
    end
  end

  assign view = '{count: count_nxt, ver_ihl: ver_nxt, tlen: tlen_nxt,
                  proto: proto_nxt, sum: sum_nxt};

  // The last byte of a packet clears the state for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      count_r <= '0;
      ver_r   <= '0;
      tlen_r  <= '0;
      proto_r <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      ver_r   <= ver_nxt;
      tlen_r  <= tlen_nxt;
      proto_r <= proto_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // A new packet always starts at offset zero with an empty sum.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_last) |=> (count_r == 16'd0 && sum_r == 16'd0))
    else $error("packet state not cleared after last byte");

  // Without a step the state holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(count_r) && $stable(sum_r))
    else $error("packet state moved without a byte");

  // The count never wraps back to zero inside a packet.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_last && count_r == COUNT_MAX) |=> (count_r == COUNT_MAX))
    else $error("byte count wrapped");

endmodule

`default_nettype wire

FILE: design/ipv4_rx_header_check_top.sv
// IPv4 receive header check.
//
// The packet enters on the in_ stream one byte per transaction, network order,
// with in_tlast on its final byte. Bytes other than the last give no result;
// the last byte gives one verdict transaction on the out_ stream: status,
// matching handler slot, protocol, header length and L4 length.
// Protocol slots are written on the cfg_ channel (cfg_ready is always high);
// the user must write them only while no packet is in flight, as the block
// does not enforce it; indexes beyond the slot list are ignored.
//
// Throughput is one byte per cycle except while a last byte waits on a stall;
// the running checksum, byte counter and field capture update combinationally
// from the input register into the result register, which drives out_tvalid.
//
// A stalled receiver holds the verdict in the result register. Bytes that
// are not last keep flowing past it; a last byte waits in the input register
// with in_tready low until the verdict ahead of it is taken.
//
// Reset enables slot 0 for ICMP, disables the others, clears the packet
// state and empties both registers.
`default_nettype none

module ipv4_rx_header_check_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [7:0]                             in_tdata,  // data_byte[7:0]
  input  wire logic                                   in_tlast,  // is_last
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // status[2:0], handler_slot[4:3], protocol[12:5], header_bytes[18:13],
  // payload_bytes[34:19], zero fill above
  output logic [ipv4hc_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [ipv4hc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [ipv4hc_pkg::SLOT_REG_W-1:0]      cfg_data
);
  import ipv4hc_pkg::*;

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;
  logic                  s1_adv;
  logic                  out_valid_r;
  logic [RESULT_W-1:0]   result_r, result_nxt;
  logic [SLOT_REG_W-1:0] slot_r [REG_COUNT];
  pkt_view_t             pkt;

  status_t               status;
  logic [SLOT_W-1:0]     slot_sel;
  logic                  slot_hit;
  logic [5:0]            hl;
  logic [15:0]           total;
  logic [15:0]           l4;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r[0] <= SLOT0_RESET;
      for (int i = 1; i < REG_COUNT; i++) begin
        slot_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && ({1'b0, cfg_addr} < (CFG_ADDR_W + 1)'(REG_COUNT))) begin
      slot_r[cfg_addr[SLOT_W-1:0]] <= cfg_data;
    end
  end

  // Input register: a byte leaves it unless it is a last byte facing a full
  // result register.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ipv4hc_hdr_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .view      (pkt)
  );

  // First enabled slot whose protocol matches.
  always_comb begin
    slot_hit = 1'b0;
    slot_sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (i < REG_COUNT) begin
        if (slot_r[i][SLOT_EN_BIT] && slot_r[i][7:0] == pkt.proto) begin
          slot_hit = 1'b1;
          slot_sel = SLOT_W'(i);
        end
      end
    end
  end

  // Verdict in priority order, with the corrected total length.
  always_comb begin
    hl    = {pkt.ver_ihl[3:0], 2'b00};
    total = pkt.tlen;
    if (pkt.tlen < {10'd0, hl} || pkt.tlen > pkt.count) begin
      total = pkt.count;
    end
    l4 = total - {10'd0, hl};

    if (pkt.count < MIN_HDR_BYTES) begin
      status = ST_SHORT;
    end else if (pkt.ver_ihl[7:4] != IP_VER_EXPECTED) begin
      status = ST_VERSION;
    end else if (pkt.ver_ihl[3:0] < IHL_MIN) begin
      status = ST_IHL;
    end else if ({10'd0, hl} > pkt.count) begin
      status = ST_TRUNCATED;
    end else if (pkt.sum != SUM_GOOD) begin
      status = ST_CHECKSUM;
    end else if (slot_hit) begin
      status = ST_ACCEPT;
    end else begin
      status = ST_NO_HANDLER;
    end

    if (status != ST_ACCEPT && status != ST_NO_HANDLER) begin
      l4 = '0;
    end
    result_nxt = {l4, hl, pkt.proto, (status == ST_ACCEPT) ? slot_sel : SLOT_W'(0),
                  status};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, result_r};

  // A last byte that leaves the input register always yields a verdict.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> out_tvalid)
    else $error("last byte produced no verdict");

  // A rejected packet carries no L4 length and no slot.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != ST_ACCEPT && out_tdata[2:0] != ST_NO_HANDLER)
      |-> (out_tdata[34:19] == 16'd0 && out_tdata[4:3] == 2'd0))
    else $error("rejected verdict carries payload length or slot");

  // A waiting last byte never overwrites an untaken verdict.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !(s1_adv && s1_last_r))
    else $error("verdict overwritten while stalled");

  // A byte in the input register is not dropped while it waits.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("waiting byte lost");

endmodule

`default_nettype wire

FILE: tb/sv/ipv4_rx_header_check_top_tb.sv
`timescale 1ns / 100ps

module ipv4_rx_header_check_top_tb;
  import ipv4hc_pkg::*;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int RANDOM_BYTES  = 1300;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // One verdict as the block reports it on the result stream.
  typedef struct {
    status_t     status;
    logic [1:0]  slot;
    logic [7:0]  proto;
    logic [5:0]  hdr_bytes;
    logic [15:0] l4_bytes;
  } verdict_t;

  // Tracks the header state byte by byte, predicts each verdict and checks
  // the verdicts that come out against the oldest prediction.
  class ipv4_verdict_board;
    logic [SLOT_REG_W-1:0] slot_reg[REG_COUNT];
    logic [15:0] byte_cnt;
    logic [7:0]  ver_ihl;
    logic [15:0] hdr_tlen;
    logic [7:0]  proto;
    logic [15:0] hdr_sum;
    logic [7:0]  hi_byte;
    verdict_t    expected_verdicts[$];
    int          errors;
    int          verdicts_seen;

    function new();
      foreach (slot_reg[i]) slot_reg[i] = '0;
      slot_reg[0] = SLOT0_RESET;
      errors = 0;
      verdicts_seen = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_cnt  = '0;
      ver_ihl   = '0;
      hdr_tlen  = '0;
      proto     = '0;
      hdr_sum   = '0;
      hi_byte   = '0;
    endfunction

    // Ones-complement sum: a carry out of bit 15 wraps back into bit 0.
    function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
      int unsigned s;
      s = a + b;
      if (s > 32'h0000_FFFF) s = s - 32'h0000_FFFF;
      return s[15:0];
    endfunction

    function void apply_slot_write(logic [CFG_ADDR_W-1:0] idx, logic [SLOT_REG_W-1:0] val);
      if (idx < REG_COUNT) slot_reg[idx] = val;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [15:0] pos;
      int unsigned size;
      int unsigned hl;
      int unsigned total;
      int          i;
      verdict_t    v;
      pos = byte_cnt;
      if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 16'd1;

      // Capture the header fields at their fixed offsets.
      case (pos)
        OFS_VER_IHL: ver_ihl = b;
        OFS_TLEN_HI: hdr_tlen[15:8] = b;
        OFS_TLEN_LO: hdr_tlen[7:0] = b;
        OFS_PROTO:   proto = b;
        default: ;
      endcase

      // Big-endian words are summed as they complete, over the header only.
      if (int'(pos) < 4 * int'(ver_ihl[3:0])) begin
        if (!pos[0]) begin
          hi_byte = b;
        end else begin
          hdr_sum = fold_add(hdr_sum, {hi_byte, b});
        end
      end
      if (!last) return;

      size = byte_cnt;
      hl = 4 * ver_ihl[3:0];
      v.slot = '0;
      v.proto = proto;
      v.hdr_bytes = hl[5:0];
      v.l4_bytes = '0;

      // Checks in priority order; only a clean header reaches dispatch.
      if (size < MIN_HDR_BYTES) begin
        v.status = ST_SHORT;
      end else if (ver_ihl[7:4] != IP_VER_EXPECTED) begin
        v.status = ST_VERSION;
      end else if (ver_ihl[3:0] < IHL_MIN) begin
        v.status = ST_IHL;
      end else if (hl > size) begin
        v.status = ST_TRUNCATED;
      end else if (hdr_sum != SUM_GOOD) begin
        v.status = ST_CHECKSUM;
      end else begin
        // A total length that cannot be right falls back to the delivered size.
        total = hdr_tlen;
        if (total < hl || total > size) total = size;
        v.l4_bytes = 16'(total - hl);
        v.status = ST_NO_HANDLER;
        // Walk down so that the lowest matching slot is the one kept.
        for (i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (i < REG_COUNT && slot_reg[i][SLOT_EN_BIT] && slot_reg[i][7:0] == proto) begin
            v.status = ST_ACCEPT;
            v.slot = 2'(i);
          end
        end
      end
      expected_verdicts.push_back(v);
      clear_packet();
    endfunction

    function void compare_field(string tag, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
      end
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] d);
      verdict_t want;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, expected nothing, actual %h", $time, d);
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("status", 16'(want.status), 16'(d[2:0]));
      compare_field("handler_slot", 16'(want.slot), 16'(d[4:3]));
      compare_field("protocol", 16'(want.proto), 16'(d[12:5]));
      compare_field("header_bytes", 16'(want.hdr_bytes), 16'(d[18:13]));
      compare_field("payload_bytes", want.l4_bytes, d[34:19]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [SLOT_REG_W-1:0] cfg_data;

  ipv4_verdict_board hdr_board;
  logic [7:0]  pkt_bytes[$];
  bit          quiet_mode;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned cycle_count;

  ipv4_rx_header_check_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ipv4_rx_header_check_top verification failed");
      $finish;
    end
  end

  // Receiver side: random stalls except in quiet phases.
  always @(posedge clk) begin
    if (quiet_mode) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  // Every accepted transaction on the three channels goes to the board.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) hdr_board.apply_slot_write(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) hdr_board.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) hdr_board.check_verdict(out_tdata);
    end
  end

  // Offers one byte, with random gaps ahead of it, and waits for acceptance.
  // tvalid stays high afterwards so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet_mode) begin
      while ($urandom_range(0, 99) < 16) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_packet();
    int unsigned i;
    for (i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // Builds a packet of nbytes with random filler; the checksum is filled in
  // whenever the whole header, of at least 12 bytes, is present.
  task automatic make_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tlen, input logic [7:0] pr,
                             input bit csum_ok, input int unsigned nbytes);
    int unsigned hl;
    int unsigned i;
    logic [15:0] acc;
    pkt_bytes.delete();
    for (i = 0; i < nbytes; i++) pkt_bytes.push_back(8'($urandom));
    hl = 4 * ihl;
    if (nbytes > 0) pkt_bytes[0] = {ver, ihl};
    if (nbytes > 3) begin
      pkt_bytes[2] = tlen[15:8];
      pkt_bytes[3] = tlen[7:0];
    end
    if (nbytes > 9) pkt_bytes[9] = pr;
    if (hl >= 12 && hl <= nbytes) begin
      pkt_bytes[10] = 8'h00;
      pkt_bytes[11] = 8'h00;
      acc = '0;
      for (i = 0; i < hl; i += 2) acc = hdr_board.fold_add(acc, {pkt_bytes[i], pkt_bytes[i+1]});
      acc = ~acc;
      if (!csum_ok) acc = acc ^ 16'h0001;
      pkt_bytes[10] = acc[15:8];
      pkt_bytes[11] = acc[7:0];
    end
  endtask

  task automatic program_slot(input logic [CFG_ADDR_W-1:0] idx, input logic [SLOT_REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits for every verdict, then lets the pipeline empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (hdr_board.verdicts_seen < packets_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Slot settings per random phase, extremes first, then random ones.
  task automatic configure_phase(input int k);
    int i;
    for (i = 0; i < REG_COUNT; i++) begin
      case (k)
        0:       program_slot(CFG_ADDR_W'(i), '0);
        1:       program_slot(CFG_ADDR_W'(i), '1);
        2:       program_slot(CFG_ADDR_W'(i), (i == 0) ? SLOT_REG_W'(9'h100)
                                                       : SLOT_REG_W'($urandom));
        default: program_slot(CFG_ADDR_W'(i), SLOT_REG_W'($urandom));
      endcase
    end
    // An index past the register list must leave everything alone.
    program_slot(CFG_ADDR_W'($urandom_range(REG_COUNT, 7)), SLOT_REG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets with random content; the rest are header
  // faults, truncated headers and plain noise.
  task automatic random_packet();
    int unsigned kind;
    int unsigned hl;
    int unsigned nbytes;
    int unsigned r;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tlen;
    logic [7:0]  pr;
    kind = $urandom_range(0, 99);
    ver = IP_VER_EXPECTED;
    ihl = ($urandom_range(0, 99) < 60) ? IHL_MIN : 4'($urandom_range(5, 15));
    if ($urandom_range(0, 99) < 70) begin
      pr = hdr_board.slot_reg[$urandom_range(0, REG_COUNT - 1)][7:0];
    end else begin
      pr = 8'($urandom);
    end
    if (kind >= 70 && kind < 80) begin
      ver = 4'($urandom);
    end else if (kind >= 80 && kind < 85) begin
      ihl = 4'($urandom_range(0, 4));
    end
    hl = 4 * ihl;
    nbytes = ((hl < 20) ? 20 : hl) + $urandom_range(0, 24);
    if (kind >= 85 && kind < 90) begin
      ihl = 4'($urandom_range(6, 15));
      hl = 4 * ihl;
      nbytes = $urandom_range(20, hl - 1);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      tlen = 16'(nbytes);
    end else if (r < 85) begin
      tlen = 16'($urandom_range(hl, nbytes));
    end else begin
      tlen = 16'($urandom);
    end
    if (kind >= 90) begin
      pkt_bytes.delete();
      repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
    end else begin
      make_packet(ver, ihl, tlen, pr, $urandom_range(0, 99) < 90, nbytes);
    end
    send_packet();
  endtask

  initial begin
    int          phase;
    int unsigned phase_start;
    hdr_board    = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    quiet_mode   = 1'b0;
    bytes_sent   = 0;
    packets_sent = 0;
    cycle_count  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ICMP, TCP and UDP enabled; slot three disabled with protocol zero.
    program_slot(CFG_ADDR_W'(0), {1'b1, PROTO_ICMP});
    program_slot(CFG_ADDR_W'(1), {1'b1, PROTO_TCP});
    program_slot(CFG_ADDR_W'(2), {1'b1, PROTO_UDP});
    program_slot(CFG_ADDR_W'(3), '0);
    program_slot(CFG_ADDR_W'(7), '1);
    cfg_valid <= 1'b0;

    // Directed packets: one of each verdict and the length corner cases.
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd15, 16'd68, PROTO_TCP, 1, 68);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'hFFFF, PROTO_UDP, 1, 30);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd3, PROTO_ICMP, 1, 25);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd22, PROTO_ICMP, 1, 26);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd24, 8'h00, 1, 24);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd6, 16'd40, 8'hFF, 1, 40);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd20, PROTO_ICMP, 1, 1);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd20, PROTO_ICMP, 1, 19);
    send_packet();
    make_packet(4'd0, IHL_MIN, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    make_packet(4'd15, IHL_MIN, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd0, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd4, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd15, 16'd40, PROTO_ICMP, 1, 40);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd20, PROTO_ICMP, 0, 20);
    send_packet();
    make_packet(IP_VER_EXPECTED, 4'd15, 16'd60, PROTO_ICMP, 0, 60);
    send_packet();
    make_packet(IP_VER_EXPECTED, IHL_MIN, 16'd20, PROTO_ICMP, 1, 20);
    send_packet();
    drain();

    // Random phases, each under its own slot setting.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure_phase(phase);
      quiet_mode = (phase == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_BYTES / RANDOM_PHASES) random_packet();
      drain();
    end

    if (hdr_board.errors == 0 && hdr_board.expected_verdicts.size() == 0) begin
      $display("ipv4_rx_header_check_top verification clean");
    end else begin
      $display("ipv4_rx_header_check_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ipv4hc_pkg.sv
design/ipv4hc_hdr_track.sv
design/ipv4_rx_header_check_top.sv
tb/sv/ipv4_rx_header_check_top_tb.sv
